@@ hdl/tmp_pkg.sv @@
// shared types, constants and helpers of the trapezoid motion profile block
// no dependencies
package tmp_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DVD_W = 32 + 2 * FRAC_BITS;
    localparam int SQ_STEPS = 32;
    localparam int CNT_W = $clog2(DVD_W);
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW = $clog2(FIFO_DEPTH);

    localparam logic [1:0] CFG_DIST = 2'd0;
    localparam logic [1:0] CFG_SPEED = 2'd1;
    localparam logic [1:0] CFG_ACCEL = 2'd2;
    localparam logic [1:0] CFG_THR = 2'd3;

    typedef enum logic [2:0] {
        PH_BELOW  = 3'd0,
        PH_BEFORE = 3'd1,
        PH_ACCEL  = 3'd2,
        PH_CRUISE = 3'd3,
        PH_DECEL  = 3'd4,
        PH_DONE   = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        P_MUL_RA,
        P_MUL_VV,
        P_CMP,
        P_DIV_A,
        P_DIV_B,
        P_SQRT,
        P_SUM,
        P_DONE
    } t_plan_state;

    typedef struct packed {
        logic        valid;
        logic [31:0] r;
        logic [31:0] v;
        logic [31:0] a;
        logic [31:0] thr;
        logic [31:0] tcb;
        logic [31:0] tce;
        logic [31:0] te;
    } t_plan;

    typedef struct packed {
        t_phase      phase;
        logic [31:0] x;
    } t_item;

    function automatic logic [31:0] sat_shr(input logic [63:0] p, input int sh);
        logic [63:0] s;
        s = p >> sh;
        return (s[63:32] != 32'd0) ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

@@ hdl/trapezoid_motion_profile_top.sv @@
// trapezoid motion profile top level: an accepted input item passes the queue,
// the two multiplier stages and the output register, one item per cycle while
// the output is not stalled. after reset or any configuration write the planner
// plans a trapezoid (two 64-step divides) or a triangle (divide and 32-step root)
// with input ready low; input ready also drops while the queue is full.
// reset: synchronous active low, registers take their reset values, queue empty
module trapezoid_motion_profile_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_addr,
    input  logic [31:0]   i_cfg_wdata,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  logic [31:0]   i_s_tdata,   // elapsed_time
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output logic [135:0]  o_m_tdata,   // position, velocity, acceleration, total_time
    output logic [2:0]    o_m_tuser    // phase
);
    import tmp_pkg::*;

    t_plan  plan;
    t_item  f_item, q_item;
    logic   push, pop, full, empty;
    logic [31:0] pos, vel;
    logic [32:0] acc;
    t_phase ph;

    tmp_planner u_plan (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_addr, .i_cfg_wdata, .o_plan(plan)
    );

    tmp_front u_front (
        .i_plan(plan), .i_valid(i_s_tvalid), .i_time(i_s_tdata), .i_full(full),
        .o_ready(o_s_tready), .o_push(push), .o_item(f_item)
    );

    tmp_fifo u_fifo (
        .i_clk, .i_rst_n, .i_push(push), .i_item(f_item), .i_pop(pop),
        .o_full(full), .o_empty(empty), .o_item(q_item)
    );

    tmp_back u_back (
        .i_clk, .i_rst_n, .i_plan(plan), .i_empty(empty), .i_item(q_item),
        .o_pop(pop), .i_ready(i_m_tready), .o_valid(o_m_tvalid),
        .o_pos(pos), .o_vel(vel), .o_acc(acc), .o_phase(ph)
    );

    assign o_m_tdata = {7'd0, plan.te, acc, vel, pos};
    assign o_m_tuser = ph;

endmodule

@@ hdl/tmp_planner.sv @@
// configuration registers and profile time planner (shared divider and square root)
// depends on tmp_pkg
module tmp_planner (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_addr,
    input  logic [31:0]       i_cfg_wdata,
    output tmp_pkg::t_plan    o_plan
);
    import tmp_pkg::*;

    t_plan_state r_state, n_state;
    logic [31:0] r_dist, r_speed, r_accel, r_thr;
    logic [31:0] v_eff, a_eff;
    logic [63:0] r_p1, r_p2;
    logic        r_tri;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_dvd, r_q;
    logic [31:0] r_rem, r_den;
    logic [63:0] r_sx, r_sres, r_sone;
    logic [31:0] r_tcb, r_tce, r_te;

    logic [32:0] d_rem, d_sub;
    logic        d_ge;
    logic [DVD_W-1:0] d_q;
    logic [63:0] d_q64;
    logic [31:0] d_q32;
    logic [64:0] s_sum;
    logic        s_ge;
    logic [63:0] s_res;
    logic        last_div, last_sq;
    logic [32:0] te_sum;

    assign v_eff = (r_speed != 32'd0) ? r_speed : 32'd1;
    assign a_eff = (r_accel != 32'd0) ? r_accel : 32'd1;

    assign d_rem = {r_rem, r_dvd[DVD_W-1]};
    assign d_ge = d_rem >= {1'b0, r_den};
    assign d_sub = d_ge ? d_rem - {1'b0, r_den} : d_rem;
    assign d_q = {r_q[DVD_W-2:0], d_ge};
    assign d_q64 = ((d_q >> 64) != '0) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'(d_q);
    assign d_q32 = (d_q64[63:32] != 32'd0) ? 32'hFFFF_FFFF : d_q64[31:0];

    assign s_sum = {1'b0, r_sres} + {1'b0, r_sone};
    assign s_ge = {1'b0, r_sx} >= s_sum;
    assign s_res = s_ge ? (r_sres >> 1) + r_sone : (r_sres >> 1);

    assign last_div = r_cnt == CNT_W'(DVD_W - 1);
    assign last_sq = r_cnt == CNT_W'(SQ_STEPS - 1);
    assign te_sum = {1'b0, r_tcb} + {1'b0, r_tce};

    always_comb begin
        n_state = r_state;
        case (r_state)
            P_MUL_RA: n_state = P_MUL_VV;
            P_MUL_VV: n_state = P_CMP;
            P_CMP:    n_state = P_DIV_A;
            P_DIV_A:  if (last_div) n_state = r_tri ? P_SQRT : P_DIV_B;
            P_DIV_B:  if (last_div) n_state = P_SUM;
            P_SQRT:   if (last_sq) n_state = P_SUM;
            P_SUM:    n_state = P_DONE;
            P_DONE:   n_state = P_DONE;
            default:  n_state = P_MUL_RA;
        endcase
        if (i_cfg_we) n_state = P_MUL_RA;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= P_MUL_RA;
            r_dist <= 32'd0;
            r_speed <= 32'd1 << FRAC_BITS;
            r_accel <= 32'd1 << FRAC_BITS;
            r_thr <= 32'd0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_DIST:  r_dist <= i_cfg_wdata;
                    CFG_SPEED: r_speed <= i_cfg_wdata;
                    CFG_ACCEL: r_accel <= i_cfg_wdata;
                    CFG_THR:   r_thr <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            P_MUL_RA: r_p1 <= 64'(r_dist) * 64'(a_eff);
            P_MUL_VV: r_p2 <= 64'(v_eff) * 64'(v_eff);
            P_CMP: begin
                r_tri <= !(r_p1 > r_p2);
                r_cnt <= '0;
                r_rem <= 32'd0;
                r_q <= '0;
                r_den <= a_eff;
                if (r_p1 > r_p2) r_dvd <= DVD_W'(v_eff) << FRAC_BITS;
                else r_dvd <= DVD_W'(r_dist) << (2 * FRAC_BITS);
            end
            P_DIV_A, P_DIV_B: begin
                r_cnt <= r_cnt + 1'b1;
                r_rem <= d_sub[31:0];
                r_q <= d_q;
                r_dvd <= r_dvd << 1;
                if (last_div) begin
                    r_cnt <= '0;
                    if (r_state == P_DIV_B) begin
                        r_tce <= d_q32;
                    end else if (r_tri) begin
                        r_sx <= d_q64;
                        r_sres <= 64'd0;
                        r_sone <= 64'd1 << 62;
                    end else begin
                        r_tcb <= d_q32;
                        r_rem <= 32'd0;
                        r_q <= '0;
                        r_den <= v_eff;
                        r_dvd <= DVD_W'(r_dist) << FRAC_BITS;
                    end
                end
            end
            P_SQRT: begin
                r_cnt <= r_cnt + 1'b1;
                if (s_ge) r_sx <= r_sx - s_sum[63:0];
                r_sres <= s_res;
                r_sone <= r_sone >> 2;
                if (last_sq) begin
                    r_tcb <= s_res[31:0];
                    r_tce <= s_res[31:0];
                end
            end
            P_SUM: r_te <= te_sum[32] ? 32'hFFFF_FFFF : te_sum[31:0];
            default: ;
        endcase
    end

    always_comb begin
        o_plan.valid = r_state == P_DONE;
        o_plan.r = r_dist;
        o_plan.v = v_eff;
        o_plan.a = a_eff;
        o_plan.thr = r_thr;
        o_plan.tcb = r_tcb;
        o_plan.tce = r_tce;
        o_plan.te = r_te;
    end

endmodule

@@ hdl/tmp_front.sv @@
// input side: accepts time samples, picks the phase and the multiplier operand
// depends on tmp_pkg
module tmp_front (
    input  tmp_pkg::t_plan i_plan,
    input  logic           i_valid,
    input  logic [31:0]    i_time,
    input  logic           i_full,
    output logic           o_ready,
    output logic           o_push,
    output tmp_pkg::t_item o_item
);
    import tmp_pkg::*;

    assign o_ready = i_plan.valid && !i_full;
    assign o_push = o_ready && i_valid;

    always_comb begin
        o_item.x = i_time;
        if (i_plan.r < i_plan.thr) begin
            o_item.phase = PH_BELOW;
        end else if (i_time[31]) begin
            o_item.phase = PH_BEFORE;
        end else if (i_time < i_plan.tcb) begin
            o_item.phase = PH_ACCEL;
        end else if (i_time < i_plan.tce) begin
            o_item.phase = PH_CRUISE;
            o_item.x = i_time - (i_plan.tcb >> 1);
        end else if (i_time < i_plan.te) begin
            o_item.phase = PH_DECEL;
            o_item.x = i_plan.te - i_time;
        end else begin
            o_item.phase = PH_DONE;
        end
    end

endmodule

@@ hdl/tmp_fifo.sv @@
// short item queue between the front and back parts
// depends on tmp_pkg
module tmp_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tmp_pkg::t_item i_item,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output tmp_pkg::t_item o_item
);
    import tmp_pkg::*;

    t_item r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wp, r_rp;
    logic [FIFO_AW:0]   r_cnt;
    logic do_pop;

    assign o_full = r_cnt == (FIFO_AW + 1)'(FIFO_DEPTH);
    assign o_empty = r_cnt == '0;
    assign do_pop = i_pop && !o_empty;
    assign o_item = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (do_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (FIFO_AW + 1)'(i_push) - (FIFO_AW + 1)'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_item;
    end

endmodule

@@ hdl/tmp_back.sv @@
// back part: two multiplier stages and the output register
// depends on tmp_pkg
module tmp_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tmp_pkg::t_plan i_plan,
    input  logic           i_empty,
    input  tmp_pkg::t_item i_item,
    output logic           o_pop,
    input  logic           i_ready,
    output logic           o_valid,
    output logic [31:0]    o_pos,
    output logic [31:0]    o_vel,
    output logic [32:0]    o_acc,
    output tmp_pkg::t_phase o_phase
);
    import tmp_pkg::*;

    logic   en;
    logic   r_s1_vld, r_s2_vld, r_o_vld;
    t_phase r_s1_ph, r_s2_ph;
    logic [31:0] r_s1_x, r_s2_m;
    logic [63:0] r_s1_p, r_s2_p;
    logic [31:0] s1_m, n_pos, n_vel, dec_lo;
    logic [32:0] n_acc;
    logic [63:0] dec_d;

    assign en = !r_o_vld || i_ready;
    assign o_pop = en && !i_empty;
    assign o_valid = r_o_vld;
    assign s1_m = sat_shr(r_s1_p, FRAC_BITS);
    assign dec_d = r_s2_p >> (FRAC_BITS + 1);
    assign dec_lo = i_plan.r - dec_d[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld <= !i_empty;
            r_s2_vld <= r_s1_vld;
            r_o_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_ph <= i_item.phase;
            r_s1_x <= i_item.x;
            r_s1_p <= 64'((i_item.phase == PH_CRUISE) ? i_plan.v : i_plan.a)
                      * 64'(i_item.x);
            r_s2_ph <= r_s1_ph;
            r_s2_m <= s1_m;
            r_s2_p <= 64'(s1_m) * 64'(r_s1_x);
            o_pos <= n_pos;
            o_vel <= n_vel;
            o_acc <= n_acc;
            o_phase <= r_s2_ph;
        end
    end

    always_comb begin
        n_pos = 32'd0;
        n_vel = 32'd0;
        n_acc = 33'd0;
        case (r_s2_ph)
            PH_BELOW, PH_DONE: n_pos = i_plan.r;
            PH_ACCEL: begin
                n_pos = sat_shr(r_s2_p, FRAC_BITS + 1);
                n_vel = r_s2_m;
                n_acc = {1'b0, i_plan.a};
            end
            PH_CRUISE: begin
                n_pos = r_s2_m;
                n_vel = i_plan.v;
            end
            PH_DECEL: begin
                n_pos = (dec_d >= 64'(i_plan.r)) ? 32'd0 : dec_lo;
                n_vel = r_s2_m;
                n_acc = 33'd0 - {1'b0, i_plan.a};
            end
            default: ;
        endcase
    end

endmodule

@@ hdl/tmp_checker.sv @@
// port level checks of the trapezoid motion profile top level
// bound to trapezoid_motion_profile_top, depends on tmp_pkg
module tmp_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         o_m_tvalid,
    input logic         i_m_tready,
    input logic [135:0] o_m_tdata,
    input logic [2:0]   o_m_tuser
);
    import tmp_pkg::*;

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled output item changed");

    a_rest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == PH_BELOW || o_m_tuser == PH_BEFORE
        || o_m_tuser == PH_DONE)
        |-> o_m_tdata[96:32] == 65'd0)
        else $error("motion reported outside accel, cruise or decel");

    a_accel_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == PH_ACCEL
        |-> !o_m_tdata[96] && o_m_tdata[95:64] != 32'd0)
        else $error("accel phase without positive acceleration");

endmodule

bind trapezoid_motion_profile_top tmp_checker u_chk (.*);
